// File: hw/rtl/iee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg: shared types and codes of the infix expression evaluator
// Operator codes, status codes, divider request and response words, precedence.
// ----------------------------------------------------------------------------
package iee_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4,
		OP_EQU = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BADCHAR = 3'd1,
		ST_MISSING = 3'd2,
		ST_COUNT   = 3'd3,
		ST_DIVZERO = 3'd4,
		ST_FULL    = 3'd5,
		ST_LITOVF  = 3'd6
	} status_t;

	// Divider request: start strobe with signed operands
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [1:0] prec(input logic [2:0] op);
		logic [1:0] p;
		p = 2'd0;
		if (op == OP_ADD || op == OP_SUB) p = 2'd1;
		if (op == OP_MUL || op == OP_DIV) p = 2'd2;
		return p;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/iee_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_char_if / iee_res_if: valid/ready channels of the evaluator
// Input words carry one character; output words carry one result.
// ----------------------------------------------------------------------------
interface iee_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;
	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

interface iee_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         status;
	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/iee_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_div: signed 32-bit divider, one quotient bit per cycle
// Truncates toward zero; the most negative over minus one wraps.
// ----------------------------------------------------------------------------
module iee_div
	import iee_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

	// Restoring division on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				rem_q  <= '0;
				quo_q  <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
				dvs_q  <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
				neg_q  <= req.dividend[31] ^ req.divisor[31];
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = {done_q, (neg_q ? 32'd0 - quo_q : quo_q)};

endmodule
`default_nettype wire

// File: hw/rtl/infix_expression_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator: two-stack infix integer evaluator
// A character is latched in S_IDLE and decoded in S_CHAR; an operator passes
// S_OPCHK, S_OPRD, per reduction S_RDB, S_RDA, S_CALC (S_DIVW to divide) and
// S_PUSHOP. The last character adds S_FIN, its final reductions and S_OUT for
// the result word. One character in flight at a time. Reset clears control
// state, not final_q; stack memories are not cleared, counts guard every read.
// ----------------------------------------------------------------------------
module infix_expression_evaluator
	import iee_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	iee_char_if.sink in_ch,
	iee_res_if.source out_ch
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CHAR, S_OPCHK, S_OPRD, S_RDB, S_RDA, S_CALC, S_DIVW,
		S_PUSHOP, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// Stack memories with registered read ports
	logic [31:0] opnd_mem [STACK_DEPTH];
	logic [2:0]  oper_mem [STACK_DEPTH];
	logic [31:0] opnd_rd_q;
	logic [2:0]  oper_rd_q;
	logic        opnd_we, oper_we;
	logic [AW-1:0] opnd_wa, opnd_ra, oper_wa, oper_ra;
	logic [31:0] opnd_wd;
	logic [2:0]  oper_wd;

	logic [CW-1:0] opnd_cnt_q, oper_cnt_q;
	logic [31:0] acc_q, a_q, b_q;
	logic        in_lit_q, last_q, final_q;
	logic [2:0]  err_q, op_q, new_op_q;
	logic [7:0]  ch_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	iee_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_ff @(posedge clk) begin
		if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
		opnd_rd_q <= opnd_mem[opnd_ra];
		if (oper_we) oper_mem[oper_wa] <= oper_wd;
		oper_rd_q <= oper_mem[oper_ra];
	end

	// Decode the held character
	logic        is_dig, is_sp, is_op;
	logic [2:0]  op_code;
	logic [35:0] lit_next;
	always_comb begin
		is_dig  = (ch_q >= 8'h30) && (ch_q <= 8'h39);
		is_sp   = (ch_q == 8'h20) || ((ch_q >= 8'd9) && (ch_q <= 8'd13));
		is_op   = 1'b1;
		op_code = OP_ADD;
		case (ch_q)
			8'h2B: op_code = OP_ADD;
			8'h2D: op_code = OP_SUB;
			8'h2A: op_code = OP_MUL;
			8'h2F: op_code = OP_DIV;
			8'h5E: op_code = OP_POW;
			8'h3D: op_code = OP_EQU;
			default: is_op = 1'b0;
		endcase
		lit_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {28'd0, ch_q - 8'h30};
	end

	// Memory port control
	logic [31:0] calc_r;
	always_comb begin
		opnd_we = 1'b0; opnd_wa = opnd_cnt_q[AW-1:0]; opnd_wd = acc_q;
		oper_we = 1'b0; oper_wa = oper_cnt_q[AW-1:0]; oper_wd = new_op_q;
		opnd_ra = opnd_cnt_q[AW-1:0] - AW'(1);
		oper_ra = oper_cnt_q[AW-1:0] - AW'(1);
		div_req.start = 1'b0;
		div_req.dividend = a_q;
		div_req.divisor = b_q;
		case (op_q)
			OP_ADD: calc_r = a_q + b_q;
			OP_SUB: calc_r = a_q - b_q;
			OP_MUL: calc_r = a_q * b_q;
			default: calc_r = 32'd0;
		endcase
		case (state_q)
			S_RDB: opnd_ra = opnd_cnt_q[AW-1:0] - AW'(2);
			S_CHAR: opnd_we = err_q == ST_OK && !is_dig && (is_sp || is_op) && in_lit_q
				&& opnd_cnt_q != CW'(STACK_DEPTH);
			S_FIN: opnd_we = err_q == ST_OK && in_lit_q && opnd_cnt_q != CW'(STACK_DEPTH);
			S_CALC: begin
				opnd_wd = calc_r;
				opnd_we = op_q != OP_DIV;
				div_req.start = op_q == OP_DIV && b_q != 32'd0 &&
					!(a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF);
				if (op_q == OP_DIV && a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF) begin
					opnd_wd = 32'h8000_0000;
					opnd_we = 1'b1;
				end else if (op_q == OP_DIV) begin
					opnd_we = 1'b0;
				end
			end
			S_DIVW: begin
				opnd_wd = div_rsp.quotient;
				opnd_we = div_rsp.done;
			end
			S_PUSHOP: oper_we = oper_cnt_q != CW'(STACK_DEPTH);
			default: ;
		endcase
	end

	assign in_ch.ready = state_q == S_IDLE;

	// Sequencer: hold state, counts and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			opnd_cnt_q <= '0; oper_cnt_q <= '0;
			acc_q <= '0; in_lit_q <= 1'b0; err_q <= ST_OK;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					ch_q <= in_ch.char_code;
					last_q <= in_ch.last;
					final_q <= 1'b0;
					state_q <= S_CHAR;
				end
				S_CHAR: begin
					state_q <= last_q ? S_FIN : S_IDLE;
					if (err_q == ST_OK) begin
						if (is_dig) begin
							if (lit_next > 36'h7FFF_FFFF) err_q <= ST_LITOVF;
							else begin
								acc_q <= lit_next[31:0];
								in_lit_q <= 1'b1;
							end
						end else if (!is_sp && !is_op) begin
							err_q <= ST_BADCHAR;
						end else begin
							if (in_lit_q) begin
								in_lit_q <= 1'b0;
								acc_q <= '0;
								if (opnd_cnt_q == CW'(STACK_DEPTH)) err_q <= ST_FULL;
								else opnd_cnt_q <= opnd_cnt_q + CW'(1);
							end
							if (is_op && !(in_lit_q && opnd_cnt_q == CW'(STACK_DEPTH))) begin
								new_op_q <= op_code;
								state_q <= S_OPCHK;
							end
						end
					end
				end
				S_OPCHK: begin
					// wait for operator top read
					if (err_q != ST_OK) state_q <= final_q ? S_OUT : (last_q ? S_FIN : S_IDLE);
					else if (oper_cnt_q == '0) state_q <= final_q ? S_OUT : S_PUSHOP;
					else state_q <= S_OPRD;
				end
				S_OPRD: begin
					if (final_q || prec(new_op_q) <= prec(oper_rd_q)) begin
						op_q <= oper_rd_q;
						oper_cnt_q <= oper_cnt_q - CW'(1);
						if (opnd_cnt_q < CW'(2)) begin
							err_q <= ST_MISSING;
							state_q <= S_OPCHK;
						end else state_q <= S_RDB;
					end else state_q <= S_PUSHOP;
				end
				S_RDB: begin
					b_q <= opnd_rd_q;
					state_q <= S_RDA;
				end
				S_RDA: begin
					a_q <= opnd_rd_q;
					opnd_cnt_q <= opnd_cnt_q - CW'(2);
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (op_q == OP_DIV && b_q == 32'd0) begin
						err_q <= ST_DIVZERO;
						state_q <= S_OPCHK;
					end else if (op_q == OP_DIV &&
						!(a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF)) begin
						state_q <= S_DIVW;
					end else begin
						opnd_cnt_q <= opnd_cnt_q + CW'(1);
						state_q <= S_OPCHK;
					end
				end
				S_DIVW: if (div_rsp.done) begin
					opnd_cnt_q <= opnd_cnt_q + CW'(1);
					state_q <= S_OPCHK;
				end
				S_PUSHOP: begin
					if (oper_cnt_q == CW'(STACK_DEPTH)) err_q <= ST_FULL;
					else oper_cnt_q <= oper_cnt_q + CW'(1);
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					final_q <= 1'b1;
					if (err_q == ST_OK && in_lit_q) begin
						in_lit_q <= 1'b0;
						if (opnd_cnt_q == CW'(STACK_DEPTH)) err_q <= ST_FULL;
						else opnd_cnt_q <= opnd_cnt_q + CW'(1);
					end
					state_q <= S_OPCHK;
				end
				S_OUT: begin
					if (!out_ch.valid) begin
						// operand memory read of entry 0 pending when count is one
						out_ch.valid <= 1'b1;
						out_ch.status <= (err_q == ST_OK && opnd_cnt_q != CW'(1))
							? ST_COUNT : err_q;
						out_ch.value <= (err_q == ST_OK && opnd_cnt_q == CW'(1))
							? opnd_rd_q : 32'sd0;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						opnd_cnt_q <= '0; oper_cnt_q <= '0;
						acc_q <= '0; in_lit_q <= 1'b0; err_q <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
